@@ design/sf3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sf3_pkg: shared types and constants of the 3x3 sharpening filter
// Widths of the stream fields, line RAM geometry, register indexes and the
// records passed between the pipeline, the line RAM and the output queue.
// ----------------------------------------------------------------------------
package sf3_pkg;

    // Line RAM geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Stream field widths.
    localparam int PIX_W   = 8;
    localparam int RES_W   = 10;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 11;
    localparam int SUM_W   = 12;
    localparam int FIELD_W = RES_W + ROW_W + COL_W;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // Output queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    // One entry of the line RAM: the pixel two lines up and one line up.
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } line_pair_t;

    // Per-pixel tag computed from the counters when the pixel is taken.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pix_tag_t;

    // One finished result.
    typedef struct packed {
        logic                    last;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic signed [RES_W-1:0] filtered;
    } result_t;

    // Occupancy of the window pipeline, used for flow control.
    typedef struct packed {
        logic s1_busy;
        logic s2_busy;
    } win_status_t;

endpackage
`default_nettype wire

@@ design/sf3_line_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sf3_line_ram: line store RAM
// One synchronous RAM holding both previous lines per column. One write and
// one read per cycle, read data registered; a read of the address written in
// the same cycle returns the new data.
// ----------------------------------------------------------------------------
module sf3_line_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [sf3_pkg::ADDR_W-1:0] waddr,
    input  wire sf3_pkg::line_pair_t        wdata,
    input  wire logic                       re,
    input  wire logic [sf3_pkg::ADDR_W-1:0] raddr,
    output sf3_pkg::line_pair_t             rdata
);
    import sf3_pkg::*;

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rdata_reg;

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, write-first on an address collision.
    always_ff @(posedge clk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ design/sf3_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sf3_window: window pipeline
// Stage 1 takes the line RAM read data, shifts the 3x3 window and writes the
// column back. Stage 2 sums the window and forms twice the center minus the
// sum over 16.
// ----------------------------------------------------------------------------
module sf3_window (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clear,
    input  wire logic                       in_valid,
    input  wire logic [sf3_pkg::PIX_W-1:0]  in_px,
    input  wire sf3_pkg::pix_tag_t          in_tag,
    input  wire logic [sf3_pkg::ADDR_W-1:0] in_addr,
    input  wire sf3_pkg::line_pair_t       ram_rdata,
    output logic                            ram_we,
    output logic [sf3_pkg::ADDR_W-1:0]      ram_waddr,
    output sf3_pkg::line_pair_t             ram_wdata,
    output logic                            res_valid,
    output sf3_pkg::result_t                res,
    output sf3_pkg::win_status_t            status
);
    import sf3_pkg::*;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    pix_tag_t          s1_tag_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    logic              s2_valid_reg;
    pix_tag_t          s2_tag_reg;

    logic [PIX_W-1:0]  win_reg  [3][3];
    logic [PIX_W-1:0]  win_next [3][3];

    logic [SUM_W-1:0]  row_sum [3];
    logic [SUM_W-1:0]  win_sum;
    logic signed [RES_W-1:0] twice_center;
    logic signed [RES_W-1:0] sum_div;

    // Stage 1 capture: the pixel waits here while the RAM read completes.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        if (in_valid) begin
            s1_px_reg   <= in_px;
            s1_tag_reg  <= in_tag;
            s1_addr_reg <= in_addr;
        end
    end

    // Window shift: the new right column is the two stored lines and the pixel.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = ram_rdata.upper;
        win_next[1][2] = ram_rdata.middle;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk) begin
        if (!rst_n || clear) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    win_reg[a][b] <= '0;
                end
            end
        end else if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // Line RAM write-back: the middle line moves up, the pixel becomes middle.
    assign ram_we           = s1_valid_reg;
    assign ram_waddr        = s1_addr_reg;
    assign ram_wdata.upper  = ram_rdata.middle;
    assign ram_wdata.middle = s1_px_reg;

    // Stage 2 control: only pixels that complete an interior window go on.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg && s1_tag_reg.emit;
        end
        if (s1_valid_reg) begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // Window sum as a small tree: three row sums, then the total.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            row_sum[a] = SUM_W'(win_reg[a][0]) + SUM_W'(win_reg[a][1])
                       + SUM_W'(win_reg[a][2]);
        end
        win_sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

    assign twice_center = $signed({1'b0, win_reg[1][1], 1'b0});
    assign sum_div      = $signed(RES_W'(win_sum[SUM_W-1:4]));

    assign res_valid    = s2_valid_reg;
    assign res.filtered = twice_center - sum_div;
    assign res.row      = s2_tag_reg.row;
    assign res.col      = s2_tag_reg.col;
    assign res.last     = s2_tag_reg.last;

    assign status.s1_busy = s1_valid_reg;
    assign status.s2_busy = s2_valid_reg;

    // A result only follows a pixel that was in stage 1 the cycle before.
    a_s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("stage 2 result without a stage 1 pixel");

endmodule
`default_nettype wire

@@ design/sf3_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sf3_out_fifo: result queue
// Small queue that decouples the window pipeline from the output stream.
// The producer only pushes when space was reserved beforehand.
// ----------------------------------------------------------------------------
module sf3_out_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire sf3_pkg::result_t              push_data,
    input  wire logic                          pop,
    output logic                               out_valid,
    output sf3_pkg::result_t                   out_data,
    output logic [sf3_pkg::FIFO_LVL_W-1:0]     level
);
    import sf3_pkg::*;

    result_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_LVL_W-1:0] level_reg;
    logic                  do_pop;

    assign do_pop = pop && (level_reg != '0);

    // Storage.
    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !do_pop) begin
                level_reg <= level_reg + FIFO_LVL_W'(1);
            end else if (!push && do_pop) begin
                level_reg <= level_reg - FIFO_LVL_W'(1);
            end
        end
    end

    assign out_valid = (level_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

    // A push into a full queue would overwrite a waiting result.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg != FIFO_LVL_W'(FIFO_DEPTH)) || do_pop)
        else $error("push into a full result queue");

endmodule
`default_nettype wire

@@ design/sharpen_filter_3x3.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: a pixel that completes a window goes through the RAM read, the window
// update, then the sum and the queue write before m_tvalid shows its result.
// Throughput: one pixel per cycle, set by the single read and write port of the
// line RAM; s_tready drops only while queued results and pixels in flight fill
// the 8-entry queue. Reset: synchronous, active low; width 640 and height 480,
// counters and window cleared, line RAM contents left as they are.
// ----------------------------------------------------------------------------
// sharpen_filter_3x3: 3x3 sharpening filter, top level
// Counts pixel positions, drives the line RAM reads, runs the window pipeline
// and queues results for the output stream. Space in the result queue is
// reserved for every pixel in flight, so the input never overruns it.
// ----------------------------------------------------------------------------
module sharpen_filter_3x3 (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sf3_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sf3_pkg::TDATA_W-1:0]         m_tdata,   // [9:0] filtered,
                                                           // [25:10] out_row,
                                                           // [36:26] out_col,
                                                           // [39:37] zero
    output logic                                m_tlast,   // last_of_frame
    // Configuration writes.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sf3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sf3_pkg::*;

    logic              accept;
    logic              cfg_we;
    logic              restart;

    logic [ADDR_W-1:0]   col_reg,      col_next;
    logic [ROW_W-1:0]    row_reg,      row_next;
    logic [ADDR_W-1:0]   last_col_reg, last_col_next;
    logic [ROW_W-1:0]    last_row_reg, last_row_next;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;

    logic        at_last_col;
    logic        at_last_row;
    pix_tag_t    tag;

    line_pair_t        ram_rdata;
    line_pair_t        ram_wdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;

    logic                  res_valid;
    result_t               res;
    win_status_t           win_status;
    logic                  fifo_valid;
    result_t               fifo_data;
    logic [FIFO_LVL_W-1:0] fifo_level;
    logic [FIFO_LVL_W:0]   reserved;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;

    // Every pixel in flight holds a queue slot until it leaves the pipeline.
    assign reserved = {1'b0, fifo_level} + (FIFO_LVL_W + 1)'(win_status.s1_busy)
                    + (FIFO_LVL_W + 1)'(win_status.s2_busy);
    assign s_tready = reserved < (FIFO_LVL_W + 1)'(FIFO_DEPTH);

    // Register decode; the stored values are the last column and last row.
    assign cfg_width  = cfg_data[WIDTH_W-1:0];
    assign cfg_height = cfg_data[HEIGHT_W-1:0];

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        restart       = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    restart = 1'b1;
                    if (cfg_width == '0) begin
                        last_col_next = '0;
                    end else if (int'(cfg_width) > MAX_WIDTH) begin
                        last_col_next = ADDR_W'(MAX_WIDTH - 1);
                    end else begin
                        last_col_next = ADDR_W'(cfg_width - WIDTH_W'(1));
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    restart = 1'b1;
                    if (cfg_height == '0) begin
                        last_row_next = '0;
                    end else begin
                        last_row_next = cfg_height - HEIGHT_W'(1);
                    end
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Raster position counters.
    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= ADDR_W'(WIDTH_RESET - WIDTH_W'(1));
            last_row_reg <= HEIGHT_RESET - HEIGHT_W'(1);
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    // Tag of the pixel being taken: its window centre is one up and one left.
    assign tag.emit = (row_reg >= ROW_W'(2)) && (col_reg >= ADDR_W'(2));
    assign tag.last = at_last_col && at_last_row;
    assign tag.row  = row_reg - ROW_W'(1);
    assign tag.col  = COL_W'(col_reg - ADDR_W'(1));

    sf3_line_ram u_line_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    sf3_window u_window (
        .clk       (aclk),
        .rst_n     (aresetn),
        .clear     (restart),
        .in_valid  (accept),
        .in_px     (s_tdata),
        .in_tag    (tag),
        .in_addr   (col_reg),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .res_valid (res_valid),
        .res       (res),
        .status    (win_status)
    );

    sf3_out_fifo u_out_fifo (
        .clk       (aclk),
        .rst_n     (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tready),
        .out_valid (fifo_valid),
        .out_data  (fifo_data),
        .level     (fifo_level)
    );

    // Output beat packing.
    assign m_tvalid = fifo_valid;
    assign m_tdata  = {{(TDATA_W - FIELD_W){1'b0}}, fifo_data.col, fifo_data.row,
                       fifo_data.filtered};
    assign m_tlast  = fifo_data.last;

    a_queue_reserve: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved <= (FIFO_LVL_W + 1)'(FIFO_DEPTH))
        else $error("pixels in flight exceed the result queue space");

    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col_reg)
        else $error("column count beyond the line width");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= last_row_reg)
        else $error("row count beyond the frame height");

endmodule
`default_nettype wire

@@ test/tb_sharpen_filter_3x3.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sharpen_filter_3x3: self-checking bench for the 3x3 sharpening filter
// A short directed sequence covers the result extremes, narrow frames, a zero
// width and an ignored register index. A saturated width and random frames of many shapes follow.
// A predictor of its own keeps the line stores, the window and the counters
// and queues the expected results. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sharpen_filter_3x3;
    import sf3_pkg::*;

    // One step of the directed sequence: a register write or a pixel beat.
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [PIX_W-1:0]      pix;
        bit                    has_typed;
        result_t               typed;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: register values, two line stores, window, position.
    int unsigned      width_reg;
    int unsigned      height_reg;
    logic [PIX_W-1:0] older_line [MAX_WIDTH];
    logic [PIX_W-1:0] newer_line [MAX_WIDTH];
    logic [PIX_W-1:0] taps [3][3];
    int unsigned      cur_col;
    int unsigned      cur_row;

    result_t   sharpened_due [$];
    plan_row_t dir_plan [$];
    int        fail_count = 0;
    bit        src_calm   = 1'b0;
    bit        sink_calm  = 1'b0;

    sharpen_filter_3x3 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // A width or height write starts the frame over; the line stores keep their data.
    function automatic void rewind_frame();
        int a;
        int b;
        for (a = 0; a < 3; a++) begin
            for (b = 0; b < 3; b++) begin
                taps[a][b] = '0;
            end
        end
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic void reset_filter_state();
        int n;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (n = 0; n < MAX_WIDTH; n++) begin
            older_line[n] = '0;
            newer_line[n] = '0;
        end
        rewind_frame();
    endfunction

    // Writes to unknown indexes change nothing and do not restart the frame.
    function automatic void set_register(input logic [CFG_IDX_W-1:0]  idx,
                                         input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = val[WIDTH_W-1:0];
            rewind_frame();
        end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = val[HEIGHT_W-1:0];
            rewind_frame();
        end
    endfunction

    // Takes one pixel; returns 1 with the result when its window completes.
    function automatic bit apply_window(input logic [PIX_W-1:0] px, output result_t res);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned slot;
        int unsigned sum;
        int          val;
        int          a;
        int          b;
        // A zero size counts as one; the width saturates at the line store depth.
        w_eff = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h_eff = (height_reg == 0) ? 1 : height_reg;
        slot  = cur_col % MAX_WIDTH;
        res   = '0;
        apply_window = 1'b0;

        // Slide the window left and bring in the new column.
        for (a = 0; a < 3; a++) begin
            taps[a][0] = taps[a][1];
            taps[a][1] = taps[a][2];
        end
        taps[0][2]       = older_line[slot];
        taps[1][2]       = newer_line[slot];
        taps[2][2]       = px;
        older_line[slot] = newer_line[slot];
        newer_line[slot] = px;

        // Interior centre: twice the centre minus the window sum over 16.
        if (cur_row >= 2 && cur_col >= 2) begin
            sum = 0;
            for (a = 0; a < 3; a++) begin
                for (b = 0; b < 3; b++) begin
                    sum += taps[a][b];
                end
            end
            val          = 2 * int'(taps[1][1]) - int'(sum >> 4);
            res.filtered = val[RES_W-1:0];
            res.row      = ROW_W'(cur_row - 1);
            res.col      = COL_W'(cur_col - 1);
            res.last     = (cur_row + 1 >= h_eff) && (cur_col + 1 >= w_eff);
            apply_window = 1'b1;
        end

        // Advance the raster position, wrapping at the end of the frame.
        if (cur_col + 1 >= w_eff) begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= h_eff) ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0]  idx,
                                       input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row         = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        dir_plan.push_back(row);
    endfunction

    function automatic void plan_pixel(input logic [PIX_W-1:0] px);
        plan_row_t row;
        row     = '{default: '0};
        row.pix = px;
        dir_plan.push_back(row);
    endfunction

    function automatic void plan_pixel_typed(input logic [PIX_W-1:0]        px,
                                             input logic signed [RES_W-1:0] filt,
                                             input logic [ROW_W-1:0]        row_n,
                                             input logic [COL_W-1:0]        col_n,
                                             input logic                    last);
        plan_row_t row;
        row                = '{default: '0};
        row.pix            = px;
        row.has_typed      = 1'b1;
        row.typed.filtered = filt;
        row.typed.row      = row_n;
        row.typed.col      = col_n;
        row.typed.last     = last;
        dir_plan.push_back(row);
    endfunction

    // Drops the input valid and waits until the block has nothing in flight.
    task automatic settle();
        s_tvalid = 1'b0;
        while (sharpened_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        set_register(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Sends one pixel beat after a random gap and queues what it should cause.
    task automatic feed_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input result_t typed_res);
        int      gap;
        result_t res;
        gap = src_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        if (apply_window(px, res)) begin
            sharpened_due.push_back(typed ? typed_res : res);
        end
        @(negedge aclk);
    endtask

    // Result side: random stalls, then each beat is checked against the queue.
    initial begin
        result_t got;
        result_t want;
        int      stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.filtered = m_tdata[RES_W-1:0];
            got.row      = m_tdata[RES_W +: ROW_W];
            got.col      = m_tdata[RES_W+ROW_W +: COL_W];
            got.last     = m_tlast;
            if (sharpened_due.size() == 0) begin
                $error("unexpected result beat: filtered %0d row %0d col %0d",
                       got.filtered, got.row, got.col);
                fail_count++;
            end else begin
                want = sharpened_due.pop_front();
                if (got.filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
                    fail_count++;
                end
                if (got.row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, got.row);
                    fail_count++;
                end
                if (got.col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, got.col);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_frame: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
            @(negedge aclk);
        end
    end

    // Stimulus: reset, directed sequence, a saturated width, random frames.
    initial begin
        int               i;
        int               w;
        int               h;
        int               count;
        int               kind;
        int               random_items;
        bit               binary_pix;
        logic [PIX_W-1:0] px;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_filter_state();

        // 3x3 frame, bright centre on black: the largest result the window allows.
        plan_write(REG_IMAGE_WIDTH, 16'd3);
        plan_write(REG_IMAGE_HEIGHT, 16'd3);
        for (i = 0; i < 8; i++) plan_pixel((i == 4) ? 8'hFF : 8'h00);
        plan_pixel_typed(8'h00, 10'sd495, 16'd1, 11'd1, 1'b1);
        // 3x4 frame, white with one dark pixel: the most negative result.
        plan_write(REG_IMAGE_HEIGHT, 16'd4);
        for (i = 0; i < 8; i++) plan_pixel((i == 4) ? 8'h00 : 8'hFF);
        plan_pixel_typed(8'hFF, -10'sd127, 16'd1, 11'd1, 1'b0);
        plan_pixel(8'hFF);
        plan_pixel(8'hFF);
        plan_pixel_typed(8'hFF, 10'sd383, 16'd2, 11'd1, 1'b1);
        // A frame narrower than three has no interior.
        plan_write(REG_IMAGE_WIDTH, 16'd2);
        plan_pixel(8'h5A);
        plan_pixel(8'hA5);
        plan_pixel(8'hFF);
        // Width field of zero counts as one; the upper data bits are dropped.
        plan_write(REG_IMAGE_WIDTH, 16'hF000);
        plan_pixel(8'h3C);
        plan_pixel(8'hC3);
        // An unknown index is ignored and the frame goes on.
        plan_write(8'hFF, 16'hFFFF);
        plan_pixel(8'h81);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_plan[n]) begin
            if (dir_plan[n].is_write) begin
                write_register(dir_plan[n].reg_idx, dir_plan[n].reg_val);
            end else begin
                feed_pixel(dir_plan[n].pix, dir_plan[n].has_typed, dir_plan[n].typed);
            end
        end

        // Width field above the line store depth saturates; a short run of the first line.
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        write_register(REG_IMAGE_WIDTH, 16'hFFFF);
        write_register(REG_IMAGE_HEIGHT, 16'd3);
        repeat (24) feed_pixel(PIX_W'($urandom), 1'b0, '0);

        // Random frames: mostly whole frames of small sizes, some cut short.
        random_items = 0;
        while (random_items < 820) begin
            kind       = $urandom_range(0, 19);
            src_calm   = ($urandom_range(0, 3) == 0);
            sink_calm  = ($urandom_range(0, 3) == 0);
            binary_pix = ($urandom_range(0, 3) == 0);
            w          = $urandom_range(3, 12);
            h          = $urandom_range(3, 8);
            if (kind == 0) w = $urandom_range(0, 2);
            if (kind == 1) h = $urandom_range(0, 2);
            if (kind == 2) h = 65535;
            if (kind == 3) begin
                // Unknown index only: the current frame carries on.
                write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
                count = $urandom_range(1, 20);
            end else begin
                if ($urandom_range(0, 1) != 0) begin
                    write_register(REG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
                    write_register(REG_IMAGE_HEIGHT, 16'(h));
                end else begin
                    write_register(REG_IMAGE_HEIGHT, 16'(h));
                    write_register(REG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
                end
                if (kind <= 2) begin
                    count = $urandom_range(1, 40);
                end else if ($urandom_range(0, 3) != 0) begin
                    count = $urandom_range(1, 2) * w * h;
                end else begin
                    count = $urandom_range(1, w * h - 1);
                end
            end
            repeat (count) begin
                if (binary_pix) begin
                    px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                end else begin
                    px = PIX_W'($urandom);
                end
                feed_pixel(px, 1'b0, '0);
                random_items++;
            end
        end

        // Drain, then give a stray result time to show up.
        s_tvalid = 1'b0;
        while (sharpened_due.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && sharpened_due.size() == 0) begin
            $display("tb_sharpen_filter_3x3 OK");
        end else begin
            $display("tb_sharpen_filter_3x3 NOT OK");
        end
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial begin
        #2_000_000;
        $display("tb_sharpen_filter_3x3 NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sf3_pkg.sv
design/sf3_line_ram.sv
design/sf3_window.sv
design/sf3_out_fifo.sv
design/sharpen_filter_3x3.sv
test/tb_sharpen_filter_3x3.sv
